// ===== sv/htd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Huffman tree build and decode core.
// No dependencies; used by the interfaces and every module of the core.
package htd_pkg;

   localparam int NODE_W      = 9;
   localparam int NODE_DEPTH  = 512;
   localparam int SYM_DEPTH   = 256;
   localparam int FREQ_W      = 32;
   localparam int LEAF_FREQ_W = 24;
   localparam int CNT_W       = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;

   // Input word kinds, coded as the func field
   typedef enum logic [0:0] {
      CMD_LOAD = 1'b0,
      CMD_BYTE = 1'b1
   } cmd_kind_type;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SYMBOL_COUNT  = 1'b0,
      REG_TOTAL_SYMBOLS = 1'b1
   } csr_reg_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [7:0]              leaf_index;
      logic [7:0]              leaf_symbol;
      logic [LEAF_FREQ_W-1:0]  leaf_freq;
      logic [7:0]              code_byte;
   } cmd_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

   // Effective leaf count: clamped to 2..max_n
   function automatic logic [NODE_W-1:0] leaf_total(logic [NODE_W-1:0] sc,
                                                    logic [NODE_W-1:0] max_n);
      logic [NODE_W-1:0] r;
      if (sc < NODE_W'(2)) r = NODE_W'(2);
      else if (sc > max_n) r = max_n;
      else r = sc;
      return r;
   endfunction

   // Root index 2n-2
   function automatic logic [NODE_W-1:0] root_of(logic [NODE_W-1:0] n);
      logic [NODE_W:0] t;
      t = ({1'b0, n} << 1) - (NODE_W+1)'(2);
      return t[NODE_W-1:0];
   endfunction

endpackage

// ===== sv/htd_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the Huffman tree build and decode core.
// Depends on htd_pkg for widths.
interface htd_req_if;
   logic                            valid;
   logic                            ready;
   logic                            func;
   logic [7:0]                      leaf_index;
   logic [7:0]                      leaf_symbol;
   logic [htd_pkg::LEAF_FREQ_W-1:0] leaf_freq;
   logic [7:0]                      code_byte;
   modport source(output valid, func, leaf_index, leaf_symbol, leaf_freq, code_byte,
                  input ready);
   modport sink(input valid, func, leaf_index, leaf_symbol, leaf_freq, code_byte,
                output ready);
endinterface

interface htd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       last;
   logic       done_res;
   modport source(output valid, symbol, last, done_res, input ready);
   modport sink(input valid, symbol, last, done_res, output ready);
endinterface

interface htd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [htd_pkg::CSR_IDX_W-1:0]  index;
   logic [htd_pkg::CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/htd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input words, classifies them and holds them in a 2-deep queue.
// Depends on htd_pkg and htd_ifs.
module htd_front (
   input  logic                  clock,
   input  logic                  reset,
   htd_req_if.sink               req_ch,
   output htd_pkg::cmd_link_type cmd_link,
   input  logic                  cmd_pop
);

   htd_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   htd_pkg::cmd_type cmd_new;
   logic             push;

   // classify incoming word
   always_comb begin
      cmd_new.kind        = htd_pkg::cmd_kind_type'(req_ch.func);
      cmd_new.leaf_index  = req_ch.leaf_index;
      cmd_new.leaf_symbol = req_ch.leaf_symbol;
      cmd_new.leaf_freq   = req_ch.leaf_freq;
      cmd_new.code_byte   = req_ch.code_byte;
   end

   assign req_ch.ready = (fill_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + (push ? 2'd1 : 2'd0) - (cmd_pop ? 2'd1 : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign cmd_link.valid = (fill_ff != 2'd0);
   assign cmd_link.cmd   = slot_ff[rd_ptr_ff];

endmodule

// ===== sv/htd_back.sv =====
`timescale 1ns / 1ps
// Back end: node memories, tree build sequencer, bit-serial walk and result register.
// Depends on htd_pkg and htd_ifs.
module htd_back #(
   parameter int MAX_SYMBOLS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  htd_pkg::cmd_link_type cmd_link,
   output logic                  cmd_pop,
   htd_csr_if.sink               csr_ch,
   htd_rsp_if.source             rsp_ch
);

   localparam int NW          = htd_pkg::NODE_W;
   localparam int CHILD_DEPTH = 2 * MAX_SYMBOLS;
   localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
   localparam logic [NW-1:0] MAX_N = NW'(MAX_SYMBOLS);

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_CLR   = 13'b0000000000010,
      S_SCAN  = 13'b0000000000100,
      S_SDONE = 13'b0000000001000,
      S_MARK  = 13'b0000000010000,
      S_RDA   = 13'b0000000100000,
      S_RDB   = 13'b0000001000000,
      S_WRN   = 13'b0000010000000,
      S_CHK   = 13'b0000100000000,
      S_RD    = 13'b0001000000000,
      S_CH    = 13'b0010000000000,
      S_EM    = 13'b0100000000000,
      S_END   = 13'b1000000000000
   } state_type;

   // memories
   logic [htd_pkg::FREQ_W-1:0] freq_mem  [htd_pkg::NODE_DEPTH];
   logic                       used_mem  [htd_pkg::NODE_DEPTH];
   logic [2*NW-1:0]            child_mem [CHILD_DEPTH];
   logic [7:0]                 sym_mem   [htd_pkg::SYM_DEPTH];
   logic [htd_pkg::FREQ_W-1:0] freq_q;
   logic                       used_q;
   logic [2*NW-1:0]            child_q;
   logic [7:0]                 sym_q;

   // control state
   state_type                 state_ff, state_in;
   logic [NW-1:0]             sc_ff, sc_in;
   logic [htd_pkg::CNT_W-1:0] total_ff, total_in;
   logic [htd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [NW-1:0]             walk_ff, walk_in;
   logic                      ready_ff, ready_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      pend_ff, pend_in;

   // datapath registers
   logic [NW-1:0]              idx_ff, idx_in;
   logic [NW-1:0]              next_ff, next_in;
   logic                       take_ff, take_in;
   logic                       found_ff, found_in;
   logic [NW-1:0]              best_ff, best_in;
   logic [htd_pkg::FREQ_W-1:0] best_freq_ff, best_freq_in;
   logic                       cmp_ff, cmp_in;
   logic [NW-1:0]              cmp_idx_ff, cmp_idx_in;
   logic [NW-1:0]              a_ff, a_in;
   logic [NW-1:0]              b_ff, b_in;
   logic [htd_pkg::FREQ_W-1:0] fa_ff, fa_in;
   logic [7:0]                 byte_ff, byte_in;
   logic [2:0]                 bit_ff, bit_in;
   logic [7:0]                 pend_sym_ff, pend_sym_in;
   logic                       pend_done_ff, pend_done_in;
   logic [7:0]                 out_sym_ff, out_sym_in;
   logic                       out_last_ff, out_last_in;
   logic                       out_done_ff, out_done_in;

   // memory port controls
   logic                       freq_we, used_we, child_we, sym_we;
   logic [NW-1:0]              freq_wa, used_wa, node_ra;
   logic [htd_pkg::FREQ_W-1:0] freq_wd;
   logic                       used_wd;
   logic                       child_re, sym_re;
   logic [7:0]                 sym_ra;

   logic [NW-1:0]             n_cur, root_cur, w_sel;
   logic                      out_free, done_now;
   logic [htd_pkg::CNT_W-1:0] count_inc;
   logic                      csr_we;

   assign n_cur     = htd_pkg::leaf_total(sc_ff, MAX_N);
   assign root_cur  = htd_pkg::root_of(n_cur);
   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign count_inc = count_ff + htd_pkg::CNT_W'(1);
   assign done_now  = (count_inc >= total_ff);
   assign w_sel     = byte_ff[bit_ff] ? child_q[2*NW-1:NW] : child_q[NW-1:0];
   assign csr_we    = csr_ch.valid && csr_ch.ready;
   assign csr_ch.ready = 1'b1;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sc_in        = sc_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      walk_in      = walk_ff;
      ready_in     = ready_ff;
      pend_in      = pend_ff;
      idx_in       = idx_ff;
      next_in      = next_ff;
      take_in      = take_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      best_freq_in = best_freq_ff;
      cmp_in       = (state_ff == S_SCAN);
      cmp_idx_in   = idx_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      fa_in        = fa_ff;
      byte_in      = byte_ff;
      bit_in       = bit_ff;
      pend_sym_in  = pend_sym_ff;
      pend_done_in = pend_done_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_sym_in   = out_sym_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      cmd_pop      = 1'b0;
      freq_we      = 1'b0;
      freq_wa      = {1'b0, cmd_link.cmd.leaf_index};
      freq_wd      = htd_pkg::FREQ_W'(cmd_link.cmd.leaf_freq);
      used_we      = 1'b0;
      used_wa      = idx_ff;
      used_wd      = 1'b0;
      child_we     = 1'b0;
      sym_we       = 1'b0;
      node_ra      = idx_ff;
      child_re     = 1'b0;
      sym_re       = 1'b0;
      sym_ra       = w_sel[7:0];

      // running minimum over scanned nodes, lowest index wins ties
      if (cmp_ff && !used_q && (!found_ff || freq_q < best_freq_ff)) begin
         found_in     = 1'b1;
         best_in      = cmp_idx_ff;
         best_freq_in = freq_q;
      end

      case (state_ff)
         S_IDLE: begin
            if (cmd_link.valid) begin
               cmd_pop = 1'b1;
               if (cmd_link.cmd.kind == htd_pkg::CMD_LOAD) begin
                  freq_we  = 1'b1;
                  sym_we   = 1'b1;
                  ready_in = 1'b0;
                  count_in = '0;
                  walk_in  = root_cur;
               end else begin
                  byte_in  = cmd_link.cmd.code_byte;
                  bit_in   = 3'd7;
                  idx_in   = '0;
                  state_in = ready_ff ? S_CHK : S_CLR;
               end
            end
         end
         // clear leaf used flags
         S_CLR: begin
            used_we = 1'b1;
            used_wa = idx_ff;
            used_wd = 1'b0;
            idx_in  = idx_ff + NW'(1);
            if (idx_ff == n_cur - NW'(1)) begin
               next_in  = n_cur;
               idx_in   = '0;
               take_in  = 1'b0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            node_ra = idx_ff;
            idx_in  = idx_ff + NW'(1);
            if (idx_ff == next_ff - NW'(1)) state_in = S_SDONE;
         end
         S_SDONE: begin
            state_in = S_MARK;
         end
         S_MARK: begin
            used_we = 1'b1;
            used_wa = best_ff;
            used_wd = 1'b1;
            if (!take_ff) begin
               a_in     = best_ff;
               take_in  = 1'b1;
               found_in = 1'b0;
               idx_in   = '0;
               state_in = S_SCAN;
            end else begin
               b_in     = best_ff;
               state_in = S_RDA;
            end
         end
         S_RDA: begin
            node_ra  = a_ff;
            state_in = S_RDB;
         end
         S_RDB: begin
            node_ra  = b_ff;
            fa_in    = freq_q;
            state_in = S_WRN;
         end
         // write the new internal node
         S_WRN: begin
            freq_we  = 1'b1;
            freq_wa  = next_ff;
            freq_wd  = fa_ff + freq_q;
            used_we  = 1'b1;
            used_wa  = next_ff;
            used_wd  = 1'b0;
            child_we = 1'b1;
            next_in  = next_ff + NW'(1);
            take_in  = 1'b0;
            found_in = 1'b0;
            idx_in   = '0;
            if (next_ff == root_cur) begin
               ready_in = 1'b1;
               walk_in  = root_cur;
               state_in = S_CHK;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_CHK: begin
            state_in = (count_ff >= total_ff) ? S_IDLE : S_RD;
         end
         S_RD: begin
            child_re = 1'b1;
            state_in = S_CH;
         end
         S_CH: begin
            walk_in = w_sel;
            if (w_sel < n_cur) begin
               sym_re   = 1'b1;
               state_in = S_EM;
            end else if (bit_ff == 3'd0) begin
               state_in = S_END;
            end else begin
               bit_in   = bit_ff - 3'd1;
               state_in = S_RD;
            end
         end
         // a leaf: release the held result, hold this one
         S_EM: begin
            if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  out_valid_in = 1'b1;
                  out_sym_in   = pend_sym_ff;
                  out_last_in  = 1'b0;
                  out_done_in  = pend_done_ff;
               end
               pend_in      = 1'b1;
               pend_sym_in  = sym_q;
               pend_done_in = done_now;
               count_in     = count_inc;
               walk_in      = root_cur;
               if (done_now || bit_ff == 3'd0) begin
                  state_in = S_END;
               end else begin
                  bit_in   = bit_ff - 3'd1;
                  state_in = S_RD;
               end
            end
         end
         // the held result is the last of this word
         S_END: begin
            if (!pend_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_sym_in   = pend_sym_ff;
               out_last_in  = 1'b1;
               out_done_in  = pend_done_ff;
               pend_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // configuration writes must arrive only while idle; the block itself does not enforce this
      if (csr_we) begin
         case (csr_ch.index)
            htd_pkg::REG_SYMBOL_COUNT: begin
               sc_in    = csr_ch.data[NW-1:0];
               ready_in = 1'b0;
               walk_in  = htd_pkg::root_of(htd_pkg::leaf_total(csr_ch.data[NW-1:0], MAX_N));
            end
            htd_pkg::REG_TOTAL_SYMBOLS: begin
               total_in = csr_ch.data;
            end
            default: begin
               total_in = total_ff;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sc_ff        <= NW'(2);
         total_ff     <= '0;
         count_ff     <= '0;
         walk_ff      <= NW'(2);
         ready_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         cmp_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sc_ff        <= sc_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         ready_ff     <= ready_in;
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
         cmp_ff       <= cmp_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      next_ff      <= next_in;
      take_ff      <= take_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_freq_ff <= best_freq_in;
      cmp_idx_ff   <= cmp_idx_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      fa_ff        <= fa_in;
      byte_ff      <= byte_in;
      bit_ff       <= bit_in;
      pend_sym_ff  <= pend_sym_in;
      pend_done_ff <= pend_done_in;
      out_sym_ff   <= out_sym_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
   end

   // node frequency and used flag memories
   always_ff @(posedge clock) begin
      if (freq_we) freq_mem[freq_wa] <= freq_wd;
      if (used_we) used_mem[used_wa] <= used_wd;
      freq_q <= freq_mem[node_ra];
      used_q <= used_mem[node_ra];
   end

   // child memory: left in the upper half
   always_ff @(posedge clock) begin
      if (child_we) child_mem[next_ff[CHILD_AW-1:0]] <= {a_ff, b_ff};
      if (child_re) child_q <= child_mem[walk_ff[CHILD_AW-1:0]];
   end

   // leaf symbol memory
   always_ff @(posedge clock) begin
      if (sym_we) sym_mem[cmd_link.cmd.leaf_index] <= cmd_link.cmd.leaf_symbol;
      if (sym_re) sym_q <= sym_mem[sym_ra];
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.symbol   = out_sym_ff;
   assign rsp_ch.last     = out_last_ff;
   assign rsp_ch.done_res = out_done_ff;

endmodule

// ===== sv/huffman_tree_build_and_decode_core.sv =====
`timescale 1ns / 1ps
// Top level of the Huffman tree build and decode core.
// Depends on htd_pkg, htd_ifs, htd_front and htd_back.

// Leaf words (func 0) are stored as the back end takes them. A code word walks the tree
// one bit at a time: the back end takes the word, checks the symbol count, reads the
// registered child memory for each bit, emits each decoded symbol and closes the word,
// and it stalls while the result register is full. The first code word after a leaf
// load or a symbol_count write first builds the tree: it clears the used flags of the n
// leaves, then for each of the n-1 merges runs two linear minimum scans over the live
// nodes, one node per cycle through the frequency memory, and merges in the states
// S_RDA, S_RDB and S_WRN. A two-word queue lets the input side run ahead of the
// back end.
module huffman_tree_build_and_decode_core #(
   parameter int MAX_SYMBOLS = 256
) (
   input logic       clock,
   input logic       reset,
   htd_req_if.sink   req_ch,
   htd_rsp_if.source rsp_ch,
   htd_csr_if.sink   csr_ch
);

   htd_pkg::cmd_link_type cmd_link;
   logic                  cmd_pop;

   htd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .cmd_link(cmd_link),
      .cmd_pop (cmd_pop)
   );

   htd_back #(
      .MAX_SYMBOLS(MAX_SYMBOLS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cmd_link(cmd_link),
      .cmd_pop (cmd_pop),
      .csr_ch  (csr_ch),
      .rsp_ch  (rsp_ch)
   );

   // back end never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_link.valid)
      else $error("queue popped while empty");

   // a result that reaches the count closes its word
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.done_res |-> rsp_ch.last)
      else $error("done result not marked last");

   // reset empties the result register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

endmodule

// ===== tb/htd_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard for the Huffman tree build and decode core: watches the request,
// result and register channels, predicts decoded symbols and compares them.
// Depends on htd_pkg and the channel interfaces in htd_ifs.
module htd_scoreboard (
   input  logic clock,
   input  logic reset,
   htd_req_if   req_ch,
   htd_rsp_if   rsp_ch,
   htd_csr_if   csr_ch,
   output int   errors,
   output int   pending
);

   localparam int LEAF_LIMIT = 256;

   typedef struct {
      logic [7:0] symbol;
      logic       last;
      logic       done_res;
   } sym_word_type;

   sym_word_type expected_syms[$];

   // Shadow tree and decoder state
   logic [7:0]                    leaf_sym[htd_pkg::SYM_DEPTH];
   logic [htd_pkg::FREQ_W-1:0]    node_weight[htd_pkg::NODE_DEPTH];
   logic [htd_pkg::NODE_W-1:0]    child_one[htd_pkg::NODE_DEPTH];
   logic [htd_pkg::NODE_W-1:0]    child_zero[htd_pkg::NODE_DEPTH];
   logic                          taken[htd_pkg::NODE_DEPTH];
   logic [htd_pkg::NODE_W-1:0]    cursor;
   logic [htd_pkg::CNT_W-1:0]     sym_seen;
   logic                          tree_built;
   logic [htd_pkg::NODE_W-1:0]    leaf_count_reg;
   logic [htd_pkg::CNT_W-1:0]     sym_limit;

   initial errors = 0;

   function automatic int leaves_in_use();
      if (leaf_count_reg < 2) return 2;
      if (leaf_count_reg > LEAF_LIMIT) return LEAF_LIMIT;
      return int'(leaf_count_reg);
   endfunction

   // Least-weight free node below limit; lowest index wins ties
   function automatic int grab_lightest(int limit);
      int i;
      int best;
      i = 0;
      while (i < limit && taken[i]) i++;
      if (i >= limit) return 0;
      best = i;
      for (; i < limit; i++)
         if (!taken[i] && node_weight[i] < node_weight[best]) best = i;
      taken[best] = 1'b1;
      return best;
   endfunction

   function automatic void merge_tree();
      int n;
      int nxt;
      int a;
      int b;
      n = leaves_in_use();
      for (int i = 0; i < htd_pkg::NODE_DEPTH; i++) taken[i] = 1'b0;
      nxt = n;
      for (int k = 0; k + 1 < n; k++) begin
         a = grab_lightest(nxt);
         b = grab_lightest(nxt);
         node_weight[nxt] = node_weight[a] + node_weight[b];
         child_one[nxt]   = htd_pkg::NODE_W'(a);
         child_zero[nxt]  = htd_pkg::NODE_W'(b);
         taken[nxt]       = 1'b0;
         nxt++;
      end
      cursor     = htd_pkg::NODE_W'(2 * n - 2);
      tree_built = 1'b1;
   endfunction

   // Walk one code word MSB first, queueing every symbol it decodes
   function automatic void walk_code(logic [7:0] code);
      int n;
      int start;
      logic [htd_pkg::NODE_W-1:0] w;
      logic stop;
      sym_word_type s;
      if (!tree_built) merge_tree();
      if (sym_seen >= sym_limit) return;
      n     = leaves_in_use();
      start = expected_syms.size();
      stop  = 1'b0;
      for (int b = 7; b >= 0 && !stop; b--) begin
         w = code[b] ? child_one[cursor] : child_zero[cursor];
         cursor = w;
         if (w < n) begin
            sym_seen++;
            s.symbol   = leaf_sym[w[7:0]];
            s.last     = 1'b0;
            s.done_res = (sym_seen >= sym_limit);
            expected_syms.push_back(s);
            cursor = htd_pkg::NODE_W'(2 * n - 2);
            stop   = s.done_res;
         end
      end
      if (expected_syms.size() > start)
         expected_syms[expected_syms.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      sym_word_type want;
      if (reset) begin
         expected_syms.delete();
         for (int i = 0; i < htd_pkg::NODE_DEPTH; i++) taken[i] = 1'b0;
         leaf_count_reg = htd_pkg::NODE_W'(2);
         sym_limit      = '0;
         cursor         = htd_pkg::NODE_W'(2);
         sym_seen       = '0;
         tree_built     = 1'b0;
      end else begin
         // Result channel
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_syms.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word symbol=%h last=%b done=%b", $time,
                        rsp_ch.symbol, rsp_ch.last, rsp_ch.done_res);
            end else begin
               want = expected_syms.pop_front();
               if (rsp_ch.symbol !== want.symbol) begin
                  errors++;
                  $display("%0t: symbol expected %h actual %h", $time, want.symbol,
                           rsp_ch.symbol);
               end
               if (rsp_ch.last !== want.last) begin
                  errors++;
                  $display("%0t: last expected %b actual %b", $time, want.last, rsp_ch.last);
               end
               if (rsp_ch.done_res !== want.done_res) begin
                  errors++;
                  $display("%0t: done_res expected %b actual %b", $time, want.done_res,
                           rsp_ch.done_res);
               end
            end
         end
         // Register writes
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == htd_pkg::REG_SYMBOL_COUNT) begin
               leaf_count_reg = csr_ch.data[htd_pkg::NODE_W-1:0];
               tree_built     = 1'b0;
               cursor         = htd_pkg::NODE_W'(2 * leaves_in_use() - 2);
            end else if (csr_ch.index == htd_pkg::REG_TOTAL_SYMBOLS) begin
               sym_limit = csr_ch.data;
            end
         end
         // Request channel
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.func == htd_pkg::CMD_LOAD) begin
               leaf_sym[req_ch.leaf_index]    = req_ch.leaf_symbol;
               node_weight[req_ch.leaf_index] = htd_pkg::FREQ_W'(req_ch.leaf_freq);
               tree_built = 1'b0;
               sym_seen   = '0;
               cursor     = htd_pkg::NODE_W'(2 * leaves_in_use() - 2);
            end else begin
               walk_code(req_ch.code_byte);
            end
         end
      end
      pending = expected_syms.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the testbench for huffman_tree_build_and_decode_core: clock, reset,
// stimulus, receiver stalls and verdict. Depends on htd_pkg, htd_ifs, htd_scoreboard.
module tb_top;

   localparam int WATCHDOG_LIMIT = 700000;
   localparam int LONG_HOLD      = 400;
   localparam int ITEM_GOAL      = 270;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_HALF,
      RX_SLOW,
      RX_MOSTLY
   } rx_mode_type;

   logic clock;
   logic reset;
   int   errors;
   int   pending;

   htd_req_if req_ch ();
   htd_rsp_if rsp_ch ();
   htd_csr_if csr_ch ();

   huffman_tree_build_and_decode_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   htd_scoreboard sb (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .csr_ch  (csr_ch),
      .errors  (errors),
      .pending (pending)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Receiver: stall pattern re-picked at random, plus one long hold-off
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_cycle = 0;
   int          hold_count = 0;
   logic        long_hold_go = 1'b0;
   logic        long_hold_done = 1'b0;

   always @(posedge clock) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode <= rx_mode_type'($urandom_range(0, 3));
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (long_hold_go && !long_hold_done) begin
         hold_count++;
         rsp_ch.ready <= 1'b0;
         if (hold_count >= LONG_HOLD) long_hold_done <= 1'b1;
      end else begin
         case (rx_mode)
            RX_OPEN: rsp_ch.ready <= 1'b1;
            RX_HALF: rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_SLOW: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Watchdog: cycles without any accepted word
   int quiet = 0;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   int burst_left = 0;
   int items_sent = 0;

   function automatic int clamp_leaves(int raw);
      if (raw < 2) return 2;
      if (raw > 256) return 256;
      return raw;
   endfunction

   function automatic logic [htd_pkg::LEAF_FREQ_W-1:0] pick_freq();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return htd_pkg::LEAF_FREQ_W'($urandom_range(0, 3));
         default: return htd_pkg::LEAF_FREQ_W'($urandom);
      endcase
   endfunction

   // One request word, with bursts and gaps on the sender side
   task automatic send_word(htd_pkg::cmd_kind_type kind, logic [7:0] idx, logic [7:0] sym,
                            logic [htd_pkg::LEAF_FREQ_W-1:0] freq, logic [7:0] code);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.func        <= kind;
      req_ch.leaf_index  <= idx;
      req_ch.leaf_symbol <= sym;
      req_ch.leaf_freq   <= freq;
      req_ch.code_byte   <= code;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic load_leaf(logic [7:0] idx, logic [7:0] sym,
                            logic [htd_pkg::LEAF_FREQ_W-1:0] freq);
      send_word(htd_pkg::CMD_LOAD, idx, sym, freq, 8'($urandom));
   endtask

   task automatic send_code(logic [7:0] code);
      send_word(htd_pkg::CMD_BYTE, 8'($urandom), 8'($urandom),
                htd_pkg::LEAF_FREQ_W'($urandom), code);
   endtask

   task automatic csr_write(htd_pkg::csr_reg_type idx, logic [htd_pkg::CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drain results, then allow for a rebuild plus queued bytes that decode nothing
   task automatic settle(int n);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(posedge clock);
      repeat (3 * n * n + 8 * n + 100) @(posedge clock);
   endtask

   task automatic run_phase(int raw_n, logic [htd_pkg::CNT_W-1:0] total, int nbytes,
                            bit reload_mid);
      int n;
      n = clamp_leaves(raw_n);
      csr_write(htd_pkg::REG_SYMBOL_COUNT, htd_pkg::CSR_DATA_W'(raw_n));
      csr_write(htd_pkg::REG_TOTAL_SYMBOLS, total);
      for (int i = 0; i < n; i++) load_leaf(8'(i), 8'($urandom), pick_freq());
      // stored but outside the tree
      if (n < 256 && $urandom_range(0, 1))
         load_leaf(8'($urandom_range(n, 255)), 8'($urandom), pick_freq());
      for (int b = 0; b < nbytes; b++) begin
         if (reload_mid && b == nbytes / 2)
            load_leaf(8'($urandom_range(0, n - 1)), 8'($urandom), pick_freq());
         send_code(8'($urandom));
      end
      settle(n);
   endtask

   initial begin
      int raw;
      logic [htd_pkg::CNT_W-1:0] total;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.func  <= htd_pkg::CMD_LOAD;
      req_ch.leaf_index  <= '0;
      req_ch.leaf_symbol <= '0;
      req_ch.leaf_freq   <= '0;
      req_ch.code_byte   <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= htd_pkg::REG_SYMBOL_COUNT;
      csr_ch.data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Two leaves at the frequency extremes, plus an index outside the tree
      csr_write(htd_pkg::REG_SYMBOL_COUNT, 2);
      csr_write(htd_pkg::REG_TOTAL_SYMBOLS, 32'hFFFF_FFFF);
      load_leaf(8'h00, 8'h00, '0);
      load_leaf(8'h01, 8'hFF, '1);
      load_leaf(8'hFF, 8'h5A, 24'h123456);
      send_code(8'h00);
      send_code(8'hFF);
      send_code(8'hA5);
      send_code(8'h5A);
      settle(2);

      // Three tied leaves; total reached inside a byte, later bytes ignored
      csr_write(htd_pkg::REG_SYMBOL_COUNT, 3);
      csr_write(htd_pkg::REG_TOTAL_SYMBOLS, 5);
      load_leaf(8'h00, 8'h11, 24'd5);
      load_leaf(8'h01, 8'h22, 24'd5);
      load_leaf(8'h02, 8'h33, 24'd5);
      send_code(8'hFF);
      send_code(8'h00);
      send_code(8'h96);
      send_code(8'h3C);
      settle(3);

      // Zero total: code bytes ignored
      csr_write(htd_pkg::REG_TOTAL_SYMBOLS, 0);
      send_code(8'h77);
      settle(3);

      // Count clamped up to two; total lowered below the count, then a load restarts it
      csr_write(htd_pkg::REG_SYMBOL_COUNT, 0);
      csr_write(htd_pkg::REG_TOTAL_SYMBOLS, 3);
      send_code(8'h55);
      load_leaf(8'h00, 8'hC7, 24'd9);
      send_code(8'hC3);
      settle(2);

      // Random phases; the first one runs into a long receiver hold-off
      long_hold_go <= 1'b1;
      run_phase(4, 32'hFFFF_FFFF, 30, 1'b0);
      while (items_sent < ITEM_GOAL) begin
         case ($urandom_range(0, 19))
            0: raw = $urandom_range(0, 1);
            1: raw = $urandom_range(13, 40);
            default: raw = $urandom_range(2, 12);
         endcase
         case ($urandom_range(0, 5))
            0: total = htd_pkg::CNT_W'($urandom_range(1, 20));
            1: total = htd_pkg::CNT_W'($urandom);
            default: total = 32'hFFFF_FFFF;
         endcase
         run_phase(raw, total, $urandom_range(4, 16), ($urandom_range(0, 3) == 0));
      end

      repeat (200) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/htd_pkg.sv
sv/htd_ifs.sv
sv/htd_front.sv
sv/htd_back.sv
sv/huffman_tree_build_and_decode_core.sv
tb/htd_scoreboard.sv
tb/tb_top.sv
